### rtl/iwht_pkg.sv
package iwht_pkg;

    // Field widths of the external words.
    localparam int COEFF_W     = 21;
    localparam int PIX_W       = 12;
    localparam int CFG_W       = 4;
    localparam int MODE_W      = 2;
    localparam int DEPTH_W     = 4;

    // Block geometry: a 4x4 block addressed in raster order.
    localparam int POS_W       = 4;
    localparam int N_POS       = 16;

    // Arithmetic shift applied to every coefficient before the transform.
    localparam int COEFF_SHIFT = 2;

    // Working width of residuals, wide enough for both passes and DPCM sums.
    localparam int DATA_W      = 26;

    // Configuration register indexes.
    localparam logic REG_DPCM_MODE = 1'b0;
    localparam logic REG_BIT_DEPTH = 1'b1;

    // DPCM mode codes; any other code means plain transform.
    localparam logic [MODE_W-1:0] MODE_VERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HORZ = 2'd2;

    // Pixel depth limits and reset values.
    localparam logic [DEPTH_W-1:0] DEPTH_MIN   = 4'd8;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX   = 4'd12;
    localparam logic [MODE_W-1:0]  MODE_RESET  = 2'd0;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd8;

    // Raster position of the last word of a block.
    localparam logic [POS_W-1:0] LAST_POS = 4'd15;

    // Control of the lifting butterfly unit.
    typedef struct packed {
        logic       cap;
        logic [1:0] cap_idx;
        logic       step;
        logic [1:0] idx;
    } lift_ctl_t;

    // Control that travels with one residual word read from the work memory.
    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] pos;
    } recon_ctl_t;

endpackage

### rtl/inverse_wht4x4_recon_dpcm_top.sv
// Lossless 4x4 inverse Walsh-Hadamard reconstruction with optional DPCM.
// Input: one word per cycle (coeff, pred_pixel) in raster order, taken at
// a clock edge where start is high and busy is low. The sixteenth word of a
// block raises busy and starts the reconstruction.
// Configuration: wr_en, wr_index and wr_data write dpcm_mode (index 0) or
// bit_depth (index 1) at once; the values in force at the sixteenth word
// are used for that block.
// Processing: the shifted coefficients sit in a 16-word work memory with a
// single read and a single write port. Each of the eight lines (four rows,
// then four columns) is read, run through 4 lifting levels in one shared
// butterfly unit and written back.
// Output: 16 words follow the transform, one per cycle, each marked by
// strobe after the memory read, stage one and the output registers;
// last_pixel marks the sixteenth. The receiver cannot stall; every word is
// valid for exactly one cycle. busy stays high after the sixteenth word
// until the sweep has read the last word, and no new word is taken meanwhile.
// Reset clears the load counter, the sequencer and the registers to plain
// mode and 8-bit depth; memory contents are not cleared.
module inverse_wht4x4_recon_dpcm_top
    import iwht_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COEFF_W-1:0] coeff,
    input  logic [PIX_W-1:0]          pred_pixel,
    input  logic                      wr_en,
    input  logic                      wr_index,
    input  logic [CFG_W-1:0]          wr_data,
    output logic [PIX_W-1:0]          recon_pixel,
    output logic                      last_pixel,
    output logic                      strobe
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_LIFT  = 5'b00100,
        S_WRITE = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic [1:0]         line_reg, line_next;
    logic               pass_reg, pass_next;
    logic [POS_W-1:0]   emit_cnt_reg, emit_cnt_next;
    logic [POS_W-1:0]   load_cnt_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [MODE_W-1:0]  blk_mode_reg;
    logic [DEPTH_W-1:0] blk_depth_reg;
    recon_ctl_t         rd_ctl_reg, rd_ctl_next;

    logic                     accept;
    logic [1:0]               k;
    logic [POS_W-1:0]         line_addr;
    logic                     work_we;
    logic [POS_W-1:0]         work_waddr;
    logic [DATA_W-1:0]        work_wdata;
    logic [POS_W-1:0]         work_raddr;
    logic [DATA_W-1:0]        work_rdata;
    logic [PIX_W-1:0]         pred_rdata;
    logic signed [DATA_W-1:0] load_word;
    logic signed [DATA_W-1:0] lift_dout;
    lift_ctl_t                lift_ctl;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start & ~busy;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RESET;
            depth_reg <= DEPTH_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_DPCM_MODE: mode_reg  <= wr_data[MODE_W-1:0];
                REG_BIT_DEPTH: depth_reg <= wr_data;
            endcase
        end
    end

    // Load counter and the settings captured with the last word of a block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_cnt_reg  <= '0;
            blk_mode_reg  <= MODE_RESET;
            blk_depth_reg <= DEPTH_RESET;
        end
        else if (accept)
        begin
            load_cnt_reg <= load_cnt_reg + 4'd1;
            if (load_cnt_reg == LAST_POS)
            begin
                blk_mode_reg <= mode_reg;
                if (depth_reg < DEPTH_MIN)
                begin
                    blk_depth_reg <= DEPTH_MIN;
                end
                else if (depth_reg > DEPTH_MAX)
                begin
                    blk_depth_reg <= DEPTH_MAX;
                end
                else
                begin
                    blk_depth_reg <= depth_reg;
                end
            end
        end
    end

    // Sequencer over the row pass, the column pass and the output sweep.
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        line_next     = line_reg;
        pass_next     = pass_reg;
        emit_cnt_next = emit_cnt_reg;
        rd_ctl_next   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && load_cnt_reg == LAST_POS)
                begin
                    state_next = S_READ;
                    cnt_next   = '0;
                    line_next  = '0;
                    pass_next  = 1'b0;
                end
            end
            S_READ:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    state_next = S_LIFT;
                    cnt_next   = '0;
                end
            end
            S_LIFT:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd3)
                begin
                    state_next = S_WRITE;
                    cnt_next   = '0;
                end
            end
            S_WRITE:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd3)
                begin
                    cnt_next = '0;
                    if (line_reg == 2'd3)
                    begin
                        line_next = '0;
                        if (pass_reg)
                        begin
                            state_next    = S_EMIT;
                            emit_cnt_next = '0;
                        end
                        else
                        begin
                            state_next = S_READ;
                            pass_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = S_READ;
                        line_next  = line_reg + 2'd1;
                    end
                end
            end
            S_EMIT:
            begin
                rd_ctl_next.valid = 1'b1;
                rd_ctl_next.pos   = emit_cnt_reg;
                emit_cnt_next     = emit_cnt_reg + 4'd1;
                if (emit_cnt_reg == LAST_POS)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            line_reg     <= '0;
            pass_reg     <= 1'b0;
            emit_cnt_reg <= '0;
            rd_ctl_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            line_reg     <= line_next;
            pass_reg     <= pass_next;
            emit_cnt_reg <= emit_cnt_next;
            rd_ctl_reg   <= rd_ctl_next;
        end
    end

    // Address of element k of the current row or column.
    assign k         = cnt_reg[1:0];
    assign line_addr = pass_reg ? {k, line_reg} : {line_reg, k};

    // Work memory port selection: loads, write-back of a line, reads.
    assign load_word  = DATA_W'(coeff >>> COEFF_SHIFT);
    assign work_we    = accept | (state_reg == S_WRITE);
    assign work_waddr = accept ? load_cnt_reg : line_addr;
    assign work_wdata = accept ? load_word : lift_dout;
    assign work_raddr = (state_reg == S_EMIT) ? emit_cnt_reg : line_addr;

    // Butterfly control: read data arrives in the cycle after its address.
    always_comb
    begin
        lift_ctl.cap     = (state_reg == S_READ) && (cnt_reg != 3'd0);
        lift_ctl.cap_idx = 2'(cnt_reg - 3'd1);
        lift_ctl.step    = (state_reg == S_LIFT);
        lift_ctl.idx     = cnt_reg[1:0];
    end

    iwht_ram #(
        .WIDTH (DATA_W),
        .DEPTH (N_POS)
    ) u_work_mem (
        .clk   (clk),
        .we    (work_we),
        .waddr (work_waddr),
        .wdata (work_wdata),
        .raddr (work_raddr),
        .rdata (work_rdata)
    );

    iwht_ram #(
        .WIDTH (PIX_W),
        .DEPTH (N_POS)
    ) u_pred_mem (
        .clk   (clk),
        .we    (accept),
        .waddr (load_cnt_reg),
        .wdata (pred_pixel),
        .raddr (emit_cnt_reg),
        .rdata (pred_rdata)
    );

    iwht_lift u_lift (
        .clk  (clk),
        .ctl  (lift_ctl),
        .din  ($signed(work_rdata)),
        .dout (lift_dout)
    );

    iwht_recon u_recon (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (rd_ctl_reg),
        .mode        (blk_mode_reg),
        .depth       (blk_depth_reg),
        .resid       ($signed(work_rdata)),
        .pred        (pred_rdata),
        .recon_pixel (recon_pixel),
        .last_pixel  (last_pixel),
        .strobe      (strobe)
    );

endmodule

### rtl/iwht_ram.sv
module iwht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/iwht_lift.sv
module iwht_lift
    import iwht_pkg::*;
(
    input  logic                     clk,
    input  lift_ctl_t                ctl,
    input  logic signed [DATA_W-1:0] din,
    output logic signed [DATA_W-1:0] dout
);

    // Working registers named after the lifting variables.
    logic signed [DATA_W-1:0] a_reg;
    logic signed [DATA_W-1:0] b_reg;
    logic signed [DATA_W-1:0] c_reg;
    logic signed [DATA_W-1:0] d_reg;
    logic signed [DATA_W-1:0] e_reg;

    // Capture the four line values, then run the four lifting levels in turn.
    always_ff @(posedge clk)
    begin
        if (ctl.cap)
        begin
            case (ctl.cap_idx)
                2'd0:    a_reg <= din;
                2'd1:    c_reg <= din;
                2'd2:    d_reg <= din;
                default: b_reg <= din;
            endcase
        end
        else if (ctl.step)
        begin
            case (ctl.idx)
                2'd0:
                begin
                    a_reg <= a_reg + c_reg;
                    d_reg <= d_reg - b_reg;
                end
                2'd1:
                begin
                    e_reg <= (a_reg - d_reg) >>> 1;
                end
                2'd2:
                begin
                    b_reg <= e_reg - b_reg;
                    c_reg <= e_reg - c_reg;
                end
                default:
                begin
                    a_reg <= a_reg - b_reg;
                    d_reg <= d_reg + c_reg;
                end
            endcase
        end
    end

    // Results leave in line order a, b, c, d.
    always_comb
    begin
        case (ctl.idx)
            2'd0:    dout = a_reg;
            2'd1:    dout = b_reg;
            2'd2:    dout = c_reg;
            default: dout = d_reg;
        endcase
    end

endmodule

### rtl/iwht_recon.sv
module iwht_recon
    import iwht_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  recon_ctl_t               ctl,
    input  logic [MODE_W-1:0]        mode,
    input  logic [DEPTH_W-1:0]       depth,
    input  logic signed [DATA_W-1:0] resid,
    input  logic [PIX_W-1:0]         pred,
    output logic [PIX_W-1:0]         recon_pixel,
    output logic                     last_pixel,
    output logic                     strobe
);

    logic signed [DATA_W-1:0] col_acc_reg [4];
    logic signed [DATA_W-1:0] row_acc_reg;
    logic signed [DATA_W-1:0] prev;
    logic signed [DATA_W-1:0] res;

    logic                     s1_valid_reg;
    logic                     s1_last_reg;
    logic signed [DATA_W-1:0] s1_res_reg;
    logic [PIX_W-1:0]         s1_pred_reg;

    logic signed [DATA_W:0]   sum;
    logic signed [DATA_W:0]   lim_ext;
    logic [PIX_W:0]           lim;
    logic [PIX_W-1:0]         pix;

    logic                     strobe_reg;
    logic                     last_reg;
    logic [PIX_W-1:0]         recon_reg;

    // DPCM: add the running sum above (vertical) or to the left (horizontal).
    always_comb
    begin
        prev = '0;
        if (mode == MODE_VERT && ctl.pos[3:2] != 2'd0)
        begin
            prev = col_acc_reg[ctl.pos[1:0]];
        end
        else if (mode == MODE_HORZ && ctl.pos[1:0] != 2'd0)
        begin
            prev = row_acc_reg;
        end
        res = resid + prev;
    end

    // Stage one: residual after DPCM, with the running sums kept per column and row.
    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            col_acc_reg[ctl.pos[1:0]] <= res;
            row_acc_reg               <= res;
        end
        s1_last_reg <= (ctl.pos == LAST_POS);
        s1_res_reg  <= res;
        s1_pred_reg <= pred;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctl.valid;
        end
    end

    // Stage two: add the prediction and clip to the pixel range.
    always_comb
    begin
        lim     = (PIX_W + 1)'((13'd1 << depth) - 13'd1);
        lim_ext = $signed({{(DATA_W - PIX_W){1'b0}}, lim});
        sum     = $signed({s1_res_reg[DATA_W-1], s1_res_reg})
                + $signed({{(DATA_W + 1 - PIX_W){1'b0}}, s1_pred_reg});
        if (sum[DATA_W])
        begin
            pix = '0;
        end
        else if (sum > lim_ext)
        begin
            pix = lim[PIX_W-1:0];
        end
        else
        begin
            pix = sum[PIX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        recon_reg <= pix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            strobe_reg <= s1_valid_reg;
            last_reg   <= s1_valid_reg & s1_last_reg;
        end
    end

    assign recon_pixel = recon_reg;
    assign last_pixel  = last_reg;
    assign strobe      = strobe_reg;

endmodule

### rtl/iwht_check.sv
module iwht_check (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic strobe,
    input logic last_pixel
);

    // The end-of-block flag only comes with a word.
    assert property (@(posedge clk) disable iff (!rst_n) last_pixel |-> strobe)
        else $error("last_pixel without strobe");

    // The sixteen words of a block come in one unbroken burst.
    assert property (@(posedge clk) disable iff (!rst_n) strobe && !last_pixel |=> strobe)
        else $error("gap inside an output burst");

    // Nothing follows the last word of a block directly.
    assert property (@(posedge clk) disable iff (!rst_n) last_pixel |=> !strobe)
        else $error("word after the last word of a block");

    // busy rises only after an accepted word.
    assert property (@(posedge clk) disable iff (!rst_n) $rose(busy) |-> $past(start))
        else $error("busy rose without an accepted word");

    // The last word of a block appears after busy falls, once it has passed the stage-one and output registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> ##2 (strobe && last_pixel))
        else $error("last word not seen two cycles after busy fell");

endmodule

bind inverse_wht4x4_recon_dpcm_top iwht_check u_check (.*);
